[hw/rtl/frt_pkg.sv]
// Shared types, constants and codes of the fragment reassembly tracker.
`default_nettype none

package frt_pkg;

  localparam int ENTRIES   = 16;
  localparam int MAX_BYTES = 1048576;

  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TOT_W     = $clog2(MAX_BYTES + 1);
  localparam int OUT_TOT_W = 21;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    ACT_FRAG   = 3'd0,
    ACT_QUERY  = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_BUILD  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ORDER  = 2'd1,
    ST_NOROOM = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic [31:0]      key;
    logic [31:0]      last_order;
    logic [TOT_W-1:0] total;
  } entry_t;

  typedef struct packed {
    logic   done;
    logic   hit;
    idx_t   hit_idx;
    logic   free_found;
    idx_t   free_idx;
    entry_t hit_entry;
  } lookup_t;

endpackage

`default_nettype wire

[hw/rtl/frt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/frt_lookup.sv]
// Sequential key search over the context memory, one entry per cycle.
`default_nettype none

module frt_lookup import frt_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [31:0]    key,
  input  wire logic [ENTRIES-1:0] entry_valid,
  input  wire entry_t         rdata,
  output idx_t                raddr,
  output lookup_t             result
);

  logic busy;
  idx_t issue_idx;
  logic issue_done;
  logic cmp_pend;
  idx_t cmp_idx;
  logic cmp_valid;

  assign raddr     = issue_idx;
  assign cmp_valid = entry_valid[cmp_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy              <= 1'b0;
      issue_idx         <= '0;
      issue_done        <= 1'b0;
      cmp_pend          <= 1'b0;
      cmp_idx           <= '0;
      result.done       <= 1'b0;
      result.hit        <= 1'b0;
      result.free_found <= 1'b0;
    end else begin
      result.done <= 1'b0;
      if (start) begin
        busy              <= 1'b1;
        issue_idx         <= '0;
        issue_done        <= 1'b0;
        cmp_pend          <= 1'b0;
        result.hit        <= 1'b0;
        result.free_found <= 1'b0;
      end else if (busy) begin
        // Read issue runs one entry ahead of the compare.
        if (!issue_done) begin
          cmp_pend <= 1'b1;
          cmp_idx  <= issue_idx;
          if (issue_idx == idx_t'(ENTRIES - 1)) begin
            issue_done <= 1'b1;
          end else begin
            issue_idx <= issue_idx + idx_t'(1);
          end
        end else begin
          cmp_pend <= 1'b0;
        end

        if (cmp_pend) begin
          if (cmp_valid && rdata.key == key) begin
            result.hit       <= 1'b1;
            result.hit_idx   <= cmp_idx;
            result.hit_entry <= rdata;
            result.done      <= 1'b1;
            busy             <= 1'b0;
            cmp_pend         <= 1'b0;
          end else begin
            if (!cmp_valid && !result.free_found) begin
              result.free_found <= 1'b1;
              result.free_idx   <= cmp_idx;
            end
            if (cmp_idx == idx_t'(ENTRIES - 1)) begin
              result.done <= 1'b1;
              busy        <= 1'b0;
              cmp_pend    <= 1'b0;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fragment_reassembly_tracker.sv]
// Top level of the fragment reassembly tracker: control, update logic and result register.
`default_nettype none

// The tracker keeps ENTRIES reassembly contexts, each keyed by a 32-bit block id and
// holding the last accepted order number and a running byte total. Keys, orders and
// totals live in one synchronous memory; the per-entry valid bits and the build id
// counter are flip-flops. An item is taken only while the block is idle. A fragment,
// a length query or a remove searches the memory one entry per read cycle and stops
// at the first matching key, then goes to the update step. Clear all, build id and
// unused actions skip the search and go straight to the update step. The result is
// held in an output register, so the next item can be taken while an earlier result
// still waits for its transfer; the block holds an item in its update step only while
// that register is still occupied.
module fragment_reassembly_tracker import frt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  action,
  input  wire logic [31:0] block_id,
  input  wire logic [31:0] order_no,
  input  wire logic [15:0] data_len,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic             found,
  output logic [20:0]      total_length,
  output logic [31:0]      build_id
);

  // Control state.
  state_t state;
  state_t state_next;

  // Captured item.
  logic [2:0]  act_q;
  logic [31:0] id_q;
  logic [31:0] ord_q;
  logic [15:0] len_q;

  // Table state outside the memory.
  logic [ENTRIES-1:0] entry_valid;
  logic [ENTRIES-1:0] entry_valid_next;
  logic [31:0]        build_cnt;
  logic [31:0]        build_cnt_next;

  // Memory and search unit.
  idx_t    rd_addr;
  entry_t  rd_data;
  logic    wr_en;
  idx_t    wr_addr;
  entry_t  wr_data;
  logic    lk_start;
  lookup_t lk;

  // Update step results.
  logic             in_xfer;
  logic             needs_search;
  logic             out_free;
  logic             upd_fire;
  status_t          res_status;
  logic             res_found;
  logic [TOT_W-1:0] res_total;
  logic [31:0]      res_total_ext;
  logic [31:0]      res_bid;

  logic [31:0]      base_last;
  logic [TOT_W-1:0] base_total;
  logic [TOT_W:0]   sum;
  idx_t             slot;
  logic             slot_ok;
  logic             restart;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign upd_fire = (state == S_UPDATE) && out_free;

  // Only the actions that address a context need the key search.
  always_comb begin
    case (action_t'(action))
      ACT_FRAG, ACT_QUERY, ACT_REMOVE: needs_search = 1'b1;
      default:                         needs_search = 1'b0;
    endcase
  end

  assign lk_start = in_xfer && needs_search;

  frt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ctx_ram (
    .clk   (clk),
    .we    (wr_en && upd_fire),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  frt_lookup u_lookup (
    .clk         (clk),
    .rst         (rst),
    .start       (lk_start),
    .key         (id_q),
    .entry_valid (entry_valid),
    .rdata       (rd_data),
    .raddr       (rd_addr),
    .result      (lk)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the ready side of the input channel. Items are taken only
  // in idle, so the memory never sees a read and a write of one entry overlap.
  always_comb begin
    state_next = state;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = needs_search ? S_SCAN : S_UPDATE;
        end
      end
      S_SCAN: begin
        if (lk.done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Capture the item on its transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_q <= action;
      id_q  <= block_id;
      ord_q <= order_no;
      len_q <= data_len;
    end
  end

  // A found context restarts on order number one; a new context starts empty.
  assign restart    = !lk.hit || (ord_q == 32'd1);
  assign base_last  = restart ? 32'd0 : lk.hit_entry.last_order;
  assign base_total = restart ? '0 : lk.hit_entry.total;
  assign sum        = {1'b0, base_total} + (TOT_W + 1)'(len_q);
  assign slot       = lk.hit ? lk.hit_idx : lk.free_idx;
  assign slot_ok    = lk.hit || lk.free_found;

  // Read-modify-write of the addressed context and the result of the item.
  always_comb begin
    entry_valid_next = entry_valid;
    build_cnt_next   = build_cnt;
    wr_en            = 1'b0;
    wr_addr          = slot;
    wr_data          = '{key: id_q, last_order: base_last, total: base_total};
    res_status       = ST_OK;
    res_found        = 1'b0;
    res_total        = '0;
    res_bid          = 32'd0;
    case (action_t'(act_q))
      ACT_FRAG: begin
        if (!slot_ok) begin
          // Unknown id and a full table: nothing changes.
          res_status = ST_NOROOM;
        end else begin
          // A created or restarted context is written back even when the
          // fragment itself is refused.
          wr_en                  = 1'b1;
          entry_valid_next[slot] = 1'b1;
          res_found              = lk.hit;
          res_total              = base_total;
          if (ord_q != base_last + 32'd1) begin
            res_status = ST_ORDER;
          end else if (sum > (TOT_W + 1)'(MAX_BYTES)) begin
            res_status = ST_NOROOM;
          end else begin
            wr_data   = '{key: id_q, last_order: ord_q, total: sum[TOT_W-1:0]};
            res_total = sum[TOT_W-1:0];
          end
        end
      end
      ACT_QUERY: begin
        if (lk.hit) begin
          res_found = 1'b1;
          res_total = lk.hit_entry.total;
        end
      end
      ACT_REMOVE: begin
        if (lk.hit) begin
          res_found                     = 1'b1;
          entry_valid_next[lk.hit_idx]  = 1'b0;
        end
      end
      ACT_CLEAR: begin
        entry_valid_next = '0;
        build_cnt_next   = 32'd0;
      end
      ACT_BUILD: begin
        // The counter wraps and never issues zero.
        build_cnt_next = (build_cnt == 32'hFFFF_FFFF) ? 32'd1 : build_cnt + 32'd1;
        res_bid        = build_cnt_next;
      end
      default: begin
      end
    endcase
  end

  assign res_total_ext = 32'(res_total);

  // Table state and build counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      build_cnt   <= 32'd0;
    end else if (upd_fire) begin
      entry_valid <= entry_valid_next;
      build_cnt   <= build_cnt_next;
    end
  end

  // Output register: loaded in the update step, held while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      status       <= res_status;
      found        <= res_found;
      total_length <= res_total_ext[OUT_TOT_W-1:0];
      build_id     <= res_bid;
    end
  end

`ifndef SYNTHESIS
  // No table write may land while the search is running.
  a_valid_stable_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> $stable(entry_valid))
    else $error("valid bits changed during a key search");

  // A reported match is a valid entry holding the searched key.
  a_hit_is_valid_match: assert property (@(posedge clk) disable iff (rst)
    (lk.done && lk.hit) |-> (entry_valid[lk.hit_idx] && lk.hit_entry.key == id_q))
    else $error("search reported a match that is not a valid entry with the key");

  // The search finishes only while the control waits for it.
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    lk.done |-> (state == S_SCAN))
    else $error("search finished outside the search state");

  // A nonzero build id comes only with an otherwise empty result.
  a_build_result_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && build_id != 32'd0) |->
      (status == ST_OK && !found && total_length == 21'd0))
    else $error("build id result carries context fields");
`endif

endmodule

`default_nettype wire
